@@ rtl/core/vcs_pkg.sv @@
// Shared types and codes for the vector clock snapshot recorder.
`timescale 1ns / 1ps

package vcs_pkg;

  // Input modes (carried on in_tuser)
  localparam logic [2:0] MODE_LOCAL  = 3'd0;
  localparam logic [2:0] MODE_SEND   = 3'd1;
  localparam logic [2:0] MODE_RECV   = 3'd2;
  localparam logic [2:0] MODE_MARKER = 3'd3;
  localparam logic [2:0] MODE_START  = 3'd4;

  // Result kinds (carried on out_tuser)
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_MSG    = 2'd1;
  localparam logic [1:0] KIND_MARKER = 2'd2;
  localparam logic [1:0] KIND_REPORT = 2'd3;

  // Fixed field widths on the stream ports
  localparam int ID_W       = 2;
  localparam int MODE_W     = 3;
  localparam int PORT_CLK_W = 32;
  localparam int PORT_CLKS  = 3;
  localparam int IN_DATA_W  = 104;  // 2+2+3*32 = 100, padded to bytes
  localparam int OUT_DATA_W = 104;  // 2+3*32 = 98, padded to bytes
  localparam int OUT_USER_W = 3;

  // Control part of one queued job; its clock vector travels beside it
  typedef struct packed {
    logic            upd;   // one clock update or outgoing message
    logic            mk;    // markers to every other process
    logic            rep;   // snapshot report after the markers
    logic [1:0]      kind;  // kind of the update result
    logic [ID_W-1:0] peer;  // peer of the update result
    logic            rec;   // update belongs to recorded channel state
    logic [ID_W-1:0] me;    // own index, skipped in the marker run
  } vcs_job_t;

endpackage

@@ rtl/core/vcs_front.sv @@
// Front end: accepts items, keeps the clock and snapshot state, issues jobs.
`timescale 1ns / 1ps

module vcs_front #(
  parameter int NUM_PROCS   = 3,
  parameter int CLOCK_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [vcs_pkg::ID_W-1:0]               cfg_wr_data,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [vcs_pkg::MODE_W-1:0]             in_tuser,
  input  logic [vcs_pkg::IN_DATA_W-1:0]          in_tdata,
  output logic                                   job_valid,
  input  logic                                   job_ready,
  output vcs_pkg::vcs_job_t                      job,
  output logic [NUM_PROCS-1:0][CLOCK_WIDTH-1:0]  job_clock
);
  import vcs_pkg::*;

  typedef logic [NUM_PROCS-1:0][CLOCK_WIDTH-1:0] vclk_t;

  logic [ID_W-1:0]      pid_r;
  vclk_t                local_r, local_nxt;
  vclk_t                saved_r, saved_nxt;
  logic                 active_r, active_nxt;
  logic                 finished_r, finished_nxt;
  logic [NUM_PROCS-1:0] seen_r, seen_nxt;

  logic            accept;
  logic [ID_W-1:0] me;
  logic [2:0]      mode;
  logic [ID_W-1:0] src;
  logic [ID_W-1:0] dst;
  logic            src_ok;
  logic            seen_src;
  logic            emit;
  vclk_t           msg;
  vclk_t           bumped;
  vclk_t           merged;

  assign in_tready = job_ready;
  assign accept    = in_tvalid & job_ready;
  assign job_valid = accept & emit;

  assign mode   = in_tuser;
  assign src    = in_tdata[1:0];
  assign dst    = in_tdata[3:2];
  assign src_ok = (32'(src) < NUM_PROCS);
  assign me     = (32'(pid_r) >= NUM_PROCS) ? ID_W'(NUM_PROCS - 1) : pid_r;

  // Own entry bumped, then element-wise max with the message clock
  always_comb begin
    seen_src = 1'b0;
    for (int i = 0; i < NUM_PROCS; i++) begin
      msg[i]    = CLOCK_WIDTH'(in_tdata[2*ID_W + PORT_CLK_W*i +: PORT_CLK_W]);
      bumped[i] = local_r[i] + CLOCK_WIDTH'(ID_W'(i) == me);
      merged[i] = (bumped[i] < msg[i]) ? msg[i] : bumped[i];
      if (ID_W'(i) == src) begin
        seen_src = seen_r[i];
      end
    end
  end

  // Per-mode state update and job
  always_comb begin
    local_nxt    = local_r;
    saved_nxt    = saved_r;
    active_nxt   = active_r;
    finished_nxt = finished_r;
    seen_nxt     = seen_r;
    job          = '0;
    job.me       = me;
    job_clock    = local_r;
    emit         = 1'b0;
    case (mode)
      MODE_LOCAL, MODE_SEND: begin
        local_nxt = bumped;
        job_clock = bumped;
        job.upd   = 1'b1;
        job.kind  = (mode == MODE_SEND) ? KIND_MSG : KIND_UPDATE;
        job.peer  = (mode == MODE_SEND) ? dst : '0;
        emit      = 1'b1;
      end
      MODE_RECV: begin
        local_nxt = merged;
        job_clock = merged;
        job.upd   = 1'b1;
        job.kind  = KIND_UPDATE;
        job.rec   = active_r & src_ok & ~seen_src;
        emit      = 1'b1;
      end
      MODE_MARKER: begin
        if (src_ok) begin
          // first marker starts the snapshot
          if (!active_r) begin
            active_nxt = 1'b1;
            saved_nxt  = local_r;
            job.mk     = 1'b1;
            for (int i = 0; i < NUM_PROCS; i++) begin
              if (ID_W'(i) == me) seen_nxt[i] = 1'b1;
            end
          end
          for (int i = 0; i < NUM_PROCS; i++) begin
            if (ID_W'(i) == src) seen_nxt[i] = 1'b1;
          end
          if (!finished_r && (&seen_nxt)) begin
            finished_nxt = 1'b1;
            job.rep      = 1'b1;
          end
          job_clock = active_r ? saved_r : local_r;
          emit      = job.mk | job.rep;
        end
      end
      MODE_START: begin
        if (!active_r && !finished_r) begin
          active_nxt = 1'b1;
          saved_nxt  = local_r;
          job.mk     = 1'b1;
          for (int i = 0; i < NUM_PROCS; i++) begin
            if (ID_W'(i) == me) seen_nxt[i] = 1'b1;
          end
          emit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pid_r      <= '0;
      local_r    <= '0;
      saved_r    <= '0;
      active_r   <= 1'b0;
      finished_r <= 1'b0;
      seen_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        pid_r <= cfg_wr_data;
      end
      if (accept) begin
        local_r    <= local_nxt;
        saved_r    <= saved_nxt;
        active_r   <= active_nxt;
        finished_r <= finished_nxt;
        seen_r     <= seen_nxt;
      end
    end
  end

  // A finished snapshot was always started first
  a_fin_implies_active: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> active_r)
    else $error("snapshot finished without being active");

endmodule

@@ rtl/core/vcs_job_fifo.sv @@
// Short register queue of jobs between the front end and the result sequencer.
`timescale 1ns / 1ps

module vcs_job_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & ~empty;
  assign head_data = mem_r[rd_ptr_r];

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job queue popped while empty");

endmodule

@@ rtl/core/vcs_back.sv @@
// Result sequencer: expands each queued job into its run of result items.
`timescale 1ns / 1ps

module vcs_back #(
  parameter int NUM_PROCS   = 3,
  parameter int CLOCK_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   head_valid,
  input  vcs_pkg::vcs_job_t                      head_job,
  input  logic [NUM_PROCS-1:0][CLOCK_WIDTH-1:0]  head_clock,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [vcs_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic [vcs_pkg::OUT_USER_W-1:0]         out_tuser,
  output logic                                   out_tlast
);
  import vcs_pkg::*;

  localparam int SUB_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam logic [63:0] CMASK = {64{1'b1}} >> (64 - CLOCK_WIDTH);
  localparam logic [PORT_CLK_W-1:0] MARK = CMASK[PORT_CLK_W-1:0];

  logic [SUB_W-1:0] sub_r, sub_nxt;
  logic             valid_r, valid_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [ID_W-1:0]  peer_r, peer_nxt;
  logic             rec_r, rec_nxt;
  logic             last_r, last_nxt;
  logic [PORT_CLKS-1:0][PORT_CLK_W-1:0] clk_r, clk_nxt;

  logic            load;
  logic            is_marker;
  logic [ID_W-1:0] j;
  logic [63:0]     wide;

  // Output slot is free or being emptied this cycle
  assign load = head_valid & (~valid_r | out_tready);
  assign pop  = load & last_nxt;
  assign j    = ID_W'(sub_r);

  // Result number sub_r of the head job
  always_comb begin
    wide      = '0;
    is_marker = ~head_job.upd & head_job.mk & (32'(j) < NUM_PROCS - 1);
    kind_nxt  = head_job.upd ? head_job.kind : (is_marker ? KIND_MARKER : KIND_REPORT);
    peer_nxt  = head_job.upd ? head_job.peer
              : (is_marker ? j + ID_W'(j >= head_job.me) : '0);
    rec_nxt   = head_job.upd & head_job.rec;
    last_nxt  = head_job.upd | ~is_marker
              | ((32'(j) == NUM_PROCS - 2) & ~head_job.rep);
    for (int i = 0; i < PORT_CLKS; i++) begin
      clk_nxt[i] = '0;
      if (is_marker) begin
        clk_nxt[i] = MARK;
      end else if (i < NUM_PROCS) begin
        wide       = 64'(head_clock[i]);
        clk_nxt[i] = wide[PORT_CLK_W-1:0];
      end
    end
    sub_nxt   = sub_r;
    valid_nxt = valid_r & ~out_tready;
    if (load) begin
      valid_nxt = 1'b1;
      sub_nxt   = last_nxt ? '0 : sub_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      peer_r <= peer_nxt;
      rec_r  <= rec_nxt;
      last_r <= last_nxt;
      clk_r  <= clk_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_DATA_W'({clk_r, peer_r});
  assign out_tuser  = {rec_r, kind_r};
  assign out_tlast  = last_r;

  a_sub_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> sub_r == '0)
    else $error("result index left nonzero with no job pending");

  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> 32'(sub_r) < NUM_PROCS)
    else $error("result index beyond the longest run");

  a_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (kind_r == KIND_MARKER) |-> !rec_r && (peer_r != head_job.me || !load))
    else $error("marker flagged as recorded or sent to self");

endmodule

@@ rtl/core/vector_clock_snapshot_recorder.sv @@
// Top level of the vector clock snapshot recorder.
`timescale 1ns / 1ps

// Keeps one process's vector clock and its part in a marker-based snapshot.
// The front end takes one item per clock while the job queue (four jobs) has
// room; clock, marker and snapshot state are updated in that same cycle, so
// a receive is folded into the clock with one compare per entry and the next
// item can follow at once. The result sequencer behind the queue sends one
// result item per clock: local events, sends and receives give one result,
// a snapshot start gives NUM_PROCS-1 markers, a marker that starts and also
// completes the snapshot gives NUM_PROCS, so the sustained rate is one item
// per clock as long as the mix of items averages one result each. Items that
// give no result queue no job. The output register holds a result
// while the next one is prepared, so a stalled sink only fills the queue.
module vector_clock_snapshot_recorder #(
  parameter int NUM_PROCS   = 3,
  parameter int CLOCK_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [vcs_pkg::ID_W-1:0]        cfg_wr_data,   // process_id
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [vcs_pkg::MODE_W-1:0]      in_tuser,      // mode
  // sender_id, dest_id, msg_clock_0, msg_clock_1, msg_clock_2, zero pad
  input  logic [vcs_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // peer_id, clock_0, clock_1, clock_2, zero pad
  output logic [vcs_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [vcs_pkg::OUT_USER_W-1:0]  out_tuser,     // kind, recorded
  output logic                            out_tlast      // last
);
  import vcs_pkg::*;

  localparam int JOB_DEPTH = 4;
  localparam int CLKV_W    = NUM_PROCS * CLOCK_WIDTH;
  localparam int JOB_W     = $bits(vcs_job_t) + CLKV_W;

  logic                                  f_valid;
  logic                                  q_full;
  logic                                  q_empty;
  logic                                  q_pop;
  vcs_job_t                              f_job;
  logic [NUM_PROCS-1:0][CLOCK_WIDTH-1:0] f_clock;
  logic [JOB_W-1:0]                      q_head;
  vcs_job_t                              h_job;
  logic [NUM_PROCS-1:0][CLOCK_WIDTH-1:0] h_clock;

  assign h_job   = q_head[JOB_W-1:CLKV_W];
  assign h_clock = q_head[CLKV_W-1:0];

  vcs_front #(
    .NUM_PROCS  (NUM_PROCS),
    .CLOCK_WIDTH(CLOCK_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .job_valid  (f_valid),
    .job_ready  (~q_full),
    .job        (f_job),
    .job_clock  (f_clock)
  );

  vcs_job_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(JOB_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_valid),
    .push_data({f_job, f_clock}),
    .full     (q_full),
    .pop      (q_pop),
    .head_data(q_head),
    .empty    (q_empty)
  );

  vcs_back #(
    .NUM_PROCS  (NUM_PROCS),
    .CLOCK_WIDTH(CLOCK_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(~q_empty),
    .head_job  (h_job),
    .head_clock(h_clock),
    .pop       (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the vector clock snapshot recorder.
`timescale 1ns / 1ps

module tb_top;
  import vcs_pkg::*;

  localparam int NPROC       = 3;
  localparam int CW          = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 16;
  localparam int LONG_HOLD   = 100;
  localparam logic [ID_W-1:0] ID_BAD = 2'd3;   // one past the last process

  // One input item: mode on tuser, the rest on tdata
  typedef struct packed {
    logic [MODE_W-1:0]                    mode;
    logic [ID_W-1:0]                      src;
    logic [ID_W-1:0]                      dst;
    logic [PORT_CLKS-1:0][PORT_CLK_W-1:0] msg;
  } vc_event_t;

  // One result item
  typedef struct packed {
    logic [1:0]                           kind;
    logic [ID_W-1:0]                      peer;
    logic [PORT_CLKS-1:0][PORT_CLK_W-1:0] clks;
    logic                                 rec;
    logic                                 last;
  } vc_result_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [ID_W-1:0]       cfg_wr_data = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [MODE_W-1:0]     in_tuser    = '0;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  vector_clock_snapshot_recorder #(
    .NUM_PROCS  (NPROC),
    .CLOCK_WIDTH(CW)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow of the process state
  logic [CW-1:0]   live_clk [NPROC];
  logic [CW-1:0]   snap_clk [NPROC];
  logic            marker_in [NPROC];
  logic            snap_running;
  logic            snap_closed;
  logic [ID_W-1:0] proc_id;

  vc_event_t  pending_events[$];
  vc_result_t owed_results[$];

  int  gen_count;
  int  in_accepted;
  int  out_seen;
  int  markers_out;
  int  recorded_out;
  int  reports_out;
  int  mismatches;
  bit  calm;

  // Save the clock and owe one marker to every other process
  task automatic open_snapshot(input int me);
    vc_result_t r;
    snap_running = 1'b1;
    for (int i = 0; i < NPROC; i++) snap_clk[i] = live_clk[i];
    marker_in[me] = 1'b1;
    for (int i = 0; i < NPROC; i++) begin
      if (i != me) begin
        r      = '0;
        r.kind = KIND_MARKER;
        r.peer = i[ID_W-1:0];
        r.clks = '1;
        owed_results.push_back(r);
      end
    end
  endtask

  // Advance the shadow state by one item and queue the results it owes
  task automatic process_event(input vc_event_t ev);
    vc_result_t r;
    int         me;
    int         first_new;
    logic       all_seen;
    me        = (proc_id >= NPROC) ? NPROC - 1 : int'(proc_id);
    first_new = owed_results.size();
    r         = '0;
    case (ev.mode)
      MODE_LOCAL, MODE_SEND: begin
        live_clk[me] = live_clk[me] + 1'b1;
        r.kind = (ev.mode == MODE_SEND) ? KIND_MSG : KIND_UPDATE;
        r.peer = (ev.mode == MODE_SEND) ? ev.dst : '0;
        for (int i = 0; i < NPROC; i++) r.clks[i] = live_clk[i];
        owed_results.push_back(r);
      end
      MODE_RECV: begin
        live_clk[me] = live_clk[me] + 1'b1;
        for (int i = 0; i < NPROC; i++)
          if (live_clk[i] < ev.msg[i]) live_clk[i] = ev.msg[i];
        r.kind = KIND_UPDATE;
        // channel state: snapshot running and the source's marker still due
        if (snap_running && ev.src < NPROC) r.rec = !marker_in[ev.src];
        for (int i = 0; i < NPROC; i++) r.clks[i] = live_clk[i];
        owed_results.push_back(r);
      end
      MODE_MARKER: begin
        // markers from a bad source are dropped
        if (ev.src < NPROC) begin
          if (!snap_running) open_snapshot(me);
          marker_in[ev.src] = 1'b1;
          if (!snap_closed) begin
            all_seen = 1'b1;
            for (int i = 0; i < NPROC; i++)
              if (!marker_in[i]) all_seen = 1'b0;
            if (all_seen) begin
              snap_closed = 1'b1;
              r.kind      = KIND_REPORT;
              for (int i = 0; i < NPROC; i++) r.clks[i] = snap_clk[i];
              owed_results.push_back(r);
            end
          end
        end
      end
      MODE_START: begin
        // single-shot until reset
        if (!snap_running && !snap_closed) open_snapshot(me);
      end
      default: ;
    endcase
    if (owed_results.size() > first_new)
      owed_results[owed_results.size() - 1].last = 1'b1;
  endtask

  // Message clock entries in a window that follows the clocks as they grow
  function automatic logic [CW-1:0] msg_value();
    int hi;
    hi = gen_count + 20;
    if ($urandom_range(0, 9) == 0) return '0;
    return $urandom_range(hi, (hi > 80) ? hi - 80 : 0);
  endfunction

  function automatic vc_event_t make_event(input bit snap_ok);
    vc_event_t ev;
    int        pick;
    pick   = $urandom_range(0, 99);
    ev.src = ID_W'($urandom_range(0, 3));
    ev.dst = ID_W'($urandom_range(0, 3));
    for (int i = 0; i < PORT_CLKS; i++) ev.msg[i] = msg_value();
    if (pick < 15)      ev.mode = MODE_LOCAL;
    else if (pick < 35) ev.mode = MODE_SEND;
    else if (pick < 75) ev.mode = MODE_RECV;
    else if (pick < 87) ev.mode = MODE_MARKER;
    else if (pick < 92) ev.mode = MODE_START;
    else                ev.mode = MODE_W'(MODE_START + $urandom_range(1, 3));
    // keep the single snapshot for its own phase
    if (!snap_ok && ev.mode == MODE_MARKER) ev.src = ID_BAD;
    if (!snap_ok && ev.mode == MODE_START) ev.mode = MODE_LOCAL;
    return ev;
  endfunction

  function automatic vc_event_t mk(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] src,
                                   input logic [ID_W-1:0] dst, input logic [CW-1:0] m0,
                                   input logic [CW-1:0] m1, input logic [CW-1:0] m2);
    vc_event_t ev;
    ev.mode   = mode;
    ev.src    = src;
    ev.dst    = dst;
    ev.msg[0] = m0;
    ev.msg[1] = m1;
    ev.msg[2] = m2;
    return ev;
  endfunction

  task automatic queue_event(input vc_event_t ev);
    pending_events.push_back(ev);
    gen_count++;
  endtask

  task automatic queue_random(input int count, input bit snap_ok);
    repeat (count) queue_event(make_event(snap_ok));
  endtask

  task automatic write_proc_id(input logic [ID_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    proc_id      = value;
  endtask

  // Block idle: all items taken, all results back, queue drained
  task automatic wait_idle();
    while (pending_events.size() > 0 || in_tvalid || owed_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input vc_result_t want,
                               input vc_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH %s: exp kind=%0d peer=%0d clk=%h/%h/%h rec=%0b last=%0b",
               what, want.kind, want.peer, want.clks[0], want.clks[1], want.clks[2],
               want.rec, want.last);
      $display("  got kind=%0d peer=%0d clk=%h/%h/%h rec=%0b last=%0b",
               got.kind, got.peer, got.clks[0], got.clks[1], got.clks[2],
               got.rec, got.last);
    end
  endtask

  // Input driver
  vc_event_t offered;
  int        send_gap;
  int        send_span;
  bit        send_idle_ok;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        process_event(offered);
        in_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          offered    = pending_events.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= offered.mode;
          in_tdata  <= IN_DATA_W'({offered.msg, offered.dst, offered.src});
          if (!calm && send_idle_ok && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(1, 5);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      // alternate stretches with and without idling
      if (send_span == 0) begin
        send_idle_ok = ($urandom_range(0, 2) != 0);
        send_span    = $urandom_range(20, 80);
      end else begin
        send_span--;
      end
    end
  end

  // Result monitor and sink
  vc_result_t got;
  vc_result_t want;
  int         recv_gap;
  int         recv_span;
  int         hold_left;
  bit         recv_idle_ok;
  bit         long_hold_done;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser[1:0];
        got.rec  = out_tuser[2];
        got.peer = out_tdata[ID_W-1:0];
        got.clks = out_tdata[ID_W +: PORT_CLKS*PORT_CLK_W];
        got.last = out_tlast;
        out_seen++;
        if (got.kind == KIND_MARKER) markers_out++;
        if (got.kind == KIND_REPORT) reports_out++;
        if (got.rec) recorded_out++;
        if (owed_results.size() == 0) begin
          note_mismatch("result with nothing owed", '0, got);
        end else begin
          want = owed_results.pop_front();
          if (got !== want) note_mismatch("result differs", want, got);
        end
      end
      // one long hold-off while items are still coming, to back up the block
      if (!long_hold_done && out_seen >= 200 && pending_events.size() > 30) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && recv_idle_ok && $urandom_range(0, 3) == 0)
          recv_gap = $urandom_range(1, 5);
      end
      if (recv_span == 0) begin
        recv_idle_ok = ($urandom_range(0, 2) != 0);
        recv_span    = $urandom_range(20, 80);
      end else begin
        recv_span--;
      end
    end
  end

  // Watchdog on cycles without any handshake
  int quiet_cycles;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results still owed",
                 quiet_cycles, owed_results.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    int tmp;
    int order[3];
    int pick;
    for (int i = 0; i < NPROC; i++) begin
      live_clk[i]  = '0;
      snap_clk[i]  = '0;
      marker_in[i] = 1'b0;
    end
    snap_running = 1'b0;
    snap_closed  = 1'b0;
    proc_id      = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Process 2: directed corners, then plain traffic
    write_proc_id(2'd2);
    queue_event(mk(MODE_LOCAL, 0, 0, 0, 0, 0));
    for (int d = 0; d < 4; d++) queue_event(mk(MODE_SEND, 0, ID_W'(d), 0, 0, 0));
    queue_event(mk(MODE_RECV, 0, 0, 0, 0, 0));
    // bad source still updates; own entry pushed to all ones, then wraps
    queue_event(mk(MODE_RECV, ID_BAD, 0, 5, 0, '1));
    queue_event(mk(MODE_LOCAL, 0, 0, 0, 0, 0));
    queue_event(mk(MODE_SEND, 0, 2, 0, 0, 0));
    queue_event(mk(MODE_MARKER, ID_BAD, 0, 0, 0, 0));
    for (int m = 1; m <= 3; m++)
      queue_event(mk(MODE_W'(MODE_START + m), ID_BAD, ID_BAD, '1, '1, '1));
    queue_event(mk(MODE_RECV, 2, 1, 3, 7, 1));
    queue_random(110, 1'b0);
    wait_idle();

    // Out-of-range id, folded onto the last process
    write_proc_id(ID_BAD);
    queue_random(100, 1'b0);
    wait_idle();

    // Process 1: the snapshot, opened by a start or by a first marker
    write_proc_id(2'd1);
    queue_random(40, 1'b0);
    if ($urandom_range(0, 1) == 1) queue_event(mk(MODE_START, 0, 0, 0, 0, 0));
    else queue_event(mk(MODE_MARKER, ID_W'($urandom_range(0, 2)), 0, 0, 0, 0));
    order = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      pick     = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[pick];
      order[pick] = tmp;
    end
    for (int k = 0; k < NPROC; k++) begin
      repeat ($urandom_range(8, 20)) begin
        vc_event_t ev;
        ev      = make_event(1'b0);
        ev.mode = MODE_RECV;
        queue_event(ev);
      end
      if (k == 0) queue_event(mk(MODE_START, 0, 0, 0, 0, 0));
      queue_event(mk(MODE_MARKER, ID_BAD, 0, 0, 0, 0));
      queue_event(mk(MODE_MARKER, ID_W'(order[k]), 0, 0, 0, 0));
    end
    queue_random(20, 1'b1);
    wait_idle();

    // Process 0: all-ones receive, wrap of the own entry, then everything
    write_proc_id(2'd0);
    queue_event(mk(MODE_RECV, 1, 0, '1, '1, '1));
    queue_event(mk(MODE_LOCAL, 0, 0, 0, 0, 0));
    queue_event(mk(MODE_SEND, 0, 1, 0, 0, 0));
    queue_random(115, 1'b1);
    // no idling on either side for the tail of the run
    while (pending_events.size() > 60) @(posedge clk);
    calm = 1'b1;
    wait_idle();

    if (owed_results.size() > 0) begin
      mismatches++;
      $display("%0d expected results never arrived", owed_results.size());
    end
    $display("Covered %0d items over process ids 2, 3, 1 and 0; %0d results checked",
             in_accepted, out_seen);
    $display("Snapshot: %0d markers out, %0d recorded receives, %0d reports; %0d mismatches",
             markers_out, recorded_out, reports_out, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
